### sv/assert_macros.svh
// Assertion macros used by the port-level checker of the scheduler.
// No dependencies; every macro expects signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rrqs_pkg.sv
// Shared types and constants of the round-robin quantum scheduler.
// No dependencies; imported by the top level, both checkers and the testbench.
package rrqs_pkg;

  localparam int BURST_W   = 16;
  localparam int TASK_ID_W = 5;
  localparam int SLICE_W   = 8;
  localparam int QUANTUM_W = 8;
  localparam int STATUS_W  = 2;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd10;

  // Input action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_GRANT = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_IDLE  = 2'd3;

  typedef struct packed {
    logic               action;
    logic [BURST_W-1:0] burst_length;
  } rrqs_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [TASK_ID_W-1:0] task_id;
    logic [SLICE_W-1:0]   slice_length;
    logic                 task_finished;
  } rrqs_out_t;

endpackage

### sv/rrqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the remaining-time table of the scheduler.
module rrqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/round_robin_quantum_scheduler_unit.sv
// Round-robin time-slice scheduler: task table, live mask and slice sequencer.
// Depends on rrqs_pkg and rrqs_ram (remaining-time table).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------
//  in      | input     | in_valid / in_stall  | in_data  (rrqs_in_t)
//  out     | output    | out_valid / out_stall| out_data (rrqs_out_t)
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (quantum)
//
// An add is done in the cycle it is accepted. A granting step scans 1 to NUM_TASKS
// ids on the live mask, one per cycle, issues the RAM read on the live id, does the
// shared compare/subtract in S_UPDATE and loads the result from S_FIN once the output
// register is free. An idle step visits all NUM_TASKS ids, then goes to S_FIN.
// Reset clears the live mask, id counter and scan position and loads quantum 10.
// The input is stalled while an item is in work or the result register is held.
module round_robin_quantum_scheduler_unit
  import rrqs_pkg::*;
#(
  parameter int NUM_TASKS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rrqs_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rrqs_out_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [QUANTUM_W-1:0] cfg_wr_data
);

  localparam int ID_W  = $clog2(NUM_TASKS);
  localparam int CNT_W = ID_W + 1;
  localparam int IDX_W = (ID_W > TASK_ID_W) ? ID_W : TASK_ID_W;
  localparam logic [CNT_W-1:0] NUM_C    = CNT_W'(NUM_TASKS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_TASKS - 1);
  localparam logic [ID_W-1:0]  TOP_ID   = ID_W'(NUM_TASKS - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_FIN    = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [NUM_TASKS-1:0]   live_r, live_nxt;
  logic [CNT_W-1:0]       next_id_r, next_id_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ID_W-1:0]        pos_r, pos_nxt;
  logic [QUANTUM_W-1:0]   quantum_r, quantum_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rrqs_out_t              out_data_r, out_data_nxt;
  rrqs_out_t              res_r, res_nxt;

  logic                   ram_we;
  logic [ID_W-1:0]        ram_waddr;
  logic [BURST_W-1:0]     ram_wdata;
  logic                   ram_re;
  logic [BURST_W-1:0]     ram_rdata;

  logic                   in_accept;
  logic                   out_free;
  logic [CNT_W-1:0]       limit;
  logic [QUANTUM_W-1:0]   q_eff;
  logic [BURST_W-1:0]     q_wide;
  logic                   rem_fin;
  logic [BURST_W-1:0]     rem_left;
  logic [IDX_W-1:0]       pos_ext;
  logic [IDX_W-1:0]       next_ext;

  // Remaining burst time per task
  rrqs_ram #(
    .WIDTH (BURST_W),
    .DEPTH (NUM_TASKS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared slice unit: clamp quantum, compare and subtract
  assign q_eff    = (quantum_r == '0) ? QUANTUM_W'(1) : quantum_r;
  assign q_wide   = BURST_W'(q_eff);
  assign rem_fin  = ram_rdata <= q_wide;
  assign rem_left = ram_rdata - q_wide;

  assign limit    = (scan_r == '0) ? NUM_C : scan_r;
  assign pos_ext  = IDX_W'(pos_r);
  assign next_ext = IDX_W'(next_id_r[ID_W-1:0]);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    next_id_nxt   = next_id_r;
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    res_nxt       = res_r;
    quantum_nxt   = cfg_wr_en ? cfg_wr_data : quantum_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_data.action == ACT_ADD) begin
            // Add completes in this cycle
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            if (next_id_r == NUM_C) begin
              out_data_nxt.status = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = next_id_r[ID_W-1:0];
              ram_wdata = in_data.burst_length;
              // a zero burst never earns a slice: keep it out of the mask
              live_nxt[next_id_r[ID_W-1:0]] = (in_data.burst_length != '0);
              next_id_nxt           = next_id_r + CNT_W'(1);
              out_data_nxt.status   = STAT_ADDED;
              out_data_nxt.task_id  = next_ext[TASK_ID_W-1:0];
            end
          end else begin
            pos_nxt   = ID_W'(limit - CNT_W'(1));
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Visit one id per cycle, downward, wrapping to the top once
        if (live_r[pos_r]) begin
          ram_re    = 1'b1;
          state_nxt = S_UPDATE;
        end else if (cnt_r == LAST_CNT) begin
          res_nxt        = '0;
          res_nxt.status = STAT_IDLE;
          scan_nxt       = '0;
          state_nxt      = S_FIN;
        end else begin
          pos_nxt = (pos_r == '0) ? TOP_ID : pos_r - ID_W'(1);
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      S_UPDATE: begin
        // Grant the slice and write back the remaining time
        ram_we                = 1'b1;
        ram_waddr             = pos_r;
        ram_wdata             = rem_fin ? '0 : rem_left;
        res_nxt.status        = STAT_GRANT;
        res_nxt.task_id       = pos_ext[TASK_ID_W-1:0];
        res_nxt.slice_length  = rem_fin ? ram_rdata[SLICE_W-1:0] : q_eff;
        res_nxt.task_finished = rem_fin;
        if (rem_fin) begin
          live_nxt[pos_r] = 1'b0;
        end
        scan_nxt  = CNT_W'(pos_r);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      next_id_r   <= '0;
      scan_r      <= '0;
      quantum_r   <= QUANTUM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      next_id_r   <= next_id_nxt;
      scan_r      <= scan_nxt;
      quantum_r   <= quantum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan working registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### sv/rrqs_checker.sv
// Port-level checker for the round-robin quantum scheduler, bound to the top.
// Depends on rrqs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rrqs_assert_checker
  import rrqs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input rrqs_out_t            out_data
);

  // A held result keeps its value
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
               out_valid && $stable(out_data), "out held payload changed")

  // A held result blocks the input
  `ASSERT_CLK(a_in_blocked, out_valid && out_stall |-> in_stall,
              "input open while result held")

  // Idle and full results carry no id, slice or finish flag
  `ASSERT_CLK(a_no_grant_zero,
              out_valid && (out_data.status == STAT_IDLE || out_data.status == STAT_FULL)
              |-> out_data.task_id == '0 && out_data.slice_length == '0
              && !out_data.task_finished,
              "idle or full result has nonzero fields")

  // Only a granted slice may retire a task or carry a slice length
  `ASSERT_CLK(a_fin_grant,
              out_valid && out_data.status != STAT_GRANT
              |-> !out_data.task_finished && out_data.slice_length == '0,
              "slice or finish without grant")

  // A granted slice is never empty
  `ASSERT_CLK(a_grant_len,
              out_valid && out_data.status == STAT_GRANT |-> out_data.slice_length != '0,
              "empty slice granted")

endmodule

bind round_robin_quantum_scheduler_unit rrqs_assert_checker u_rrqs_checker (.*);

### sim/rrqs_checker.sv
// Result checker for the round-robin quantum scheduler: predicts each result.
// Watches the in, out and cfg ports of the block; depends on rrqs_pkg only.
// Hands the failure count, outstanding results and idle count to the bench.
module rrqs_checker
  import rrqs_pkg::*;
#(
  parameter int NUM_TASKS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  rrqs_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  rrqs_out_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [QUANTUM_W-1:0] cfg_wr_data,
  output int                   fail_count,
  output int                   pending,
  output int                   idle_count
);

  // Shadow copy of the task table and sequencer state
  logic [BURST_W-1:0]   time_left [NUM_TASKS];
  logic [NUM_TASKS-1:0] live_tasks;
  int                   ids_issued;
  int                   scan_top;
  logic [QUANTUM_W-1:0] quantum_q;
  rrqs_out_t            expected_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    idle_count = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d",
             $time / 10, what, got, want);
    fail_count++;
  endtask

  // Highest live id below bound with time left; retire zero-time entries passed.
  function automatic int next_live_below(input int bound);
    for (int i = bound - 1; i >= 0; i--) begin
      if (live_tasks[i]) begin
        if (time_left[i] != '0) return i;
        live_tasks[i] = 1'b0;
      end
    end
    return -1;
  endfunction

  // Work out the result of one transfer and advance the shadow state.
  function automatic rrqs_out_t predict_slice(input rrqs_in_t item);
    rrqs_out_t          res;
    int                 bound;
    int                 pick;
    logic [BURST_W-1:0] q;
    res = '0;
    if (item.action == ACT_ADD) begin
      if (ids_issued >= NUM_TASKS) begin
        res.status = STAT_FULL;
      end else begin
        time_left[ids_issued]  = item.burst_length;
        live_tasks[ids_issued] = 1'b1;
        res.status  = STAT_ADDED;
        res.task_id = ids_issued[TASK_ID_W-1:0];
        ids_issued++;
      end
    end else begin
      bound = (scan_top == 0 || scan_top > NUM_TASKS) ? NUM_TASKS : scan_top;
      pick = next_live_below(bound);
      // Pass exhausted: restart from the top in the same step
      if (pick < 0 && bound != NUM_TASKS) pick = next_live_below(NUM_TASKS);
      if (pick < 0) begin
        res.status = STAT_IDLE;
        scan_top   = 0;
      end else begin
        q = (quantum_q == '0) ? BURST_W'(1) : BURST_W'(quantum_q);
        if (time_left[pick] <= q) begin
          res.slice_length   = time_left[pick][SLICE_W-1:0];
          res.task_finished  = 1'b1;
          time_left[pick]    = '0;
          live_tasks[pick]   = 1'b0;
        end else begin
          res.slice_length = q[SLICE_W-1:0];
          time_left[pick]  = time_left[pick] - q;
        end
        res.status  = STAT_GRANT;
        res.task_id = pick[TASK_ID_W-1:0];
        scan_top    = pick;
      end
    end
    return res;
  endfunction

  // Track config, queue expectations and compare results at each rising edge
  always @(posedge clk) begin
    rrqs_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) time_left[i] = '0;
      live_tasks = '0;
      ids_issued = 0;
      scan_top   = 0;
      quantum_q  = QUANTUM_RESET;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) quantum_q = cfg_wr_data;
      if (in_valid && !in_stall) expected_q.push_back(predict_slice(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, status", out_data.status, -1);
        end else begin
          want = expected_q.pop_front();
          if (want.status == STAT_IDLE) idle_count++;
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.task_id !== want.task_id)
            report_mismatch("task_id", out_data.task_id, want.task_id);
          if (out_data.slice_length !== want.slice_length)
            report_mismatch("slice_length", out_data.slice_length, want.slice_length);
          if (out_data.task_finished !== want.task_finished)
            report_mismatch("task_finished", out_data.task_finished,
                            want.task_finished);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### sim/testbench.sv
// Top of the scheduler bench: clock, reset, stimulus, stalls and the verdict.
// Depends on rrqs_pkg, round_robin_quantum_scheduler_unit and rrqs_checker.
module testbench
  import rrqs_pkg::*;
();

  localparam int NUM_TASKS   = 32;
  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 400;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  rrqs_in_t             in_data     = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  rrqs_out_t            out_data;
  logic                 cfg_wr_en   = 1'b0;
  logic [QUANTUM_W-1:0] cfg_wr_data = '0;

  int   fail_count;
  int   pending;
  int   idle_count;
  int   cycles     = 0;
  bit   gaps_on    = 1'b0;
  bit   stall_on   = 1'b0;
  bit   hold_req   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  round_robin_quantum_scheduler_unit #(
    .NUM_TASKS (NUM_TASKS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  rrqs_checker #(
    .NUM_TASKS (NUM_TASKS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .idle_count  (idle_count)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall bursts, and one long hold-off on request
  initial begin
    int held;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one transfer and hold it until accepted; call and return at a falling edge.
  task automatic send_item(input logic act, input logic [BURST_W-1:0] burst);
    rrqs_in_t item;
    item.action       = act;
    item.burst_length = burst;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Pause until every result is back, then write the quantum.
  task automatic set_quantum(input logic [QUANTUM_W-1:0] q);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random transfer: mostly short bursts, some long, a few full width
  task automatic send_random(input int add_pct);
    logic               act;
    logic [BURST_W-1:0] burst;
    int                 pick;
    act  = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_STEP;
    pick = $urandom_range(0, 99);
    if (pick < 60)      burst = BURST_W'($urandom_range(0, 40));
    else if (pick < 90) burst = BURST_W'($urandom_range(0, 700));
    else if (pick < 93 || act == ACT_STEP) burst = BURST_W'($urandom);
    else                burst = BURST_W'($urandom_range(0, 2000));
    send_item(act, burst);
  endtask

  initial begin
    logic [QUANTUM_W-1:0] phase_q [5];
    int                   idle_base;
    int                   n;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle table, zero burst, extremes, slice equal to quantum,
    // pass exhaustion with restart from the top, reset quantum of 10
    send_item(ACT_STEP, 16'hFFFF);
    send_item(ACT_ADD, 16'd0);
    send_item(ACT_ADD, 16'hFFFF);
    send_item(ACT_ADD, 16'd10);
    send_item(ACT_ADD, 16'd11);
    send_item(ACT_ADD, 16'd1);
    repeat (7) send_item(ACT_STEP, 16'h0000);

    // Quantum of zero grants one unit
    set_quantum('0);
    send_item(ACT_ADD, 16'd2);
    repeat (4) send_item(ACT_STEP, 16'h5A5A);

    // Largest quantum
    set_quantum(8'd255);
    send_item(ACT_STEP, 16'h0000);
    send_item(ACT_ADD, 16'd255);
    send_item(ACT_STEP, 16'h0000);
    send_item(ACT_ADD, 16'd256);
    repeat (3) send_item(ACT_STEP, 16'h0000);

    // Random phases under several quanta
    phase_q[0] = 8'd1;
    phase_q[1] = QUANTUM_W'($urandom_range(2, 254));
    phase_q[2] = 8'd255;
    phase_q[3] = QUANTUM_W'($urandom_range(1, 20));
    phase_q[4] = 8'd0;
    foreach (phase_q[p]) begin
      set_quantum(phase_q[p]);
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if (p == 1) begin
        // Long receiver hold-off while transfers keep coming
        hold_req = 1'b1;
        repeat (20) send_random(20);
      end
      repeat (90) send_random(p < 2 ? 14 : 10);
    end

    // Last part: no idling, steps until the table drains or the step budget ends
    set_quantum(8'd255);
    gaps_on   = 1'b0;
    stall_on  = 1'b0;
    idle_base = idle_count;
    n = 0;
    while (idle_count == idle_base && n < 300) begin
      send_item(ACT_STEP, BURST_W'($urandom));
      n++;
    end
    send_item(ACT_ADD, BURST_W'($urandom));
    send_item(ACT_STEP, BURST_W'($urandom));

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (NUM_TASKS + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/rrqs_pkg.sv
sv/rrqs_ram.sv
sv/round_robin_quantum_scheduler_unit.sv
sv/rrqs_checker.sv
sim/rrqs_checker.sv
sim/testbench.sv
